FILE: rtl/vrrb_pkg.sv
// Package for the variable-length record ring buffer.
// Holds operation and status codes, field widths and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package vrrb_pkg;

    localparam int LEN_W            = 12;
    localparam int BUFFER_BYTES_DEF = 4096;
    localparam int HEADER_BYTES_DEF = 5;

    localparam logic [1:0] OP_BEGIN   = 2'd0;
    localparam logic [1:0] OP_PAYLOAD = 2'd1;
    localparam logic [1:0] OP_DRAIN   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_SEQUENCE = 2'd2;
    localparam logic [1:0] ST_NOTHING  = 2'd3;

endpackage

FILE: rtl/vrrb_ram.sv
// Generic synchronous RAM with one write port and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module vrrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/variable_record_ring_buffer.sv
// Top level of the variable-length record ring buffer: sequencer around one byte RAM.
// Depends on vrrb_pkg and vrrb_ram.
//
// Channel  Dir  tdata (low bit up)                           tuser
// s_*      in   entry_length[11:0], data_byte[19:12]          operation[1:0]
// m_*      out  data_out[7:0], drained_entry_length[19:8],   status[1:0],
//               free_bytes[FW+19:20]                          data_valid[2]
//
// One request at a time. A begin writes both header bytes in turn; a payload byte
// is written, the last one also marking the header ready; a drain byte is read if
// a record is open for reading, else its header is read first, each skipped ring
// tail being a step of its own. Steps are set by the single RAM write port and the
// registered RAM read. While a result waits in the output register, a new request
// is taken; the next result waits behind it. Reset is synchronous; no clearing pass.
`timescale 1ns / 1ps

module variable_record_ring_buffer
    import vrrb_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    localparam int AW = $clog2(BUFFER_BYTES),
    localparam int FW = AW + 1,
    localparam int OW = ((8 + LEN_W + FW + 7) / 8) * 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [23:0]   i_s_tdata,   // entry_length[11:0], data_byte[19:12]
    input  logic [1:0]    i_s_tuser,   // operation[1:0]
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [OW-1:0] o_m_tdata,   // data_out, drained_entry_length, free_bytes
    output logic [2:0]    o_m_tuser,   // status[1:0], data_valid[2]
    output logic          o_m_tlast
);

    localparam int SW = ((AW > LEN_W) ? AW : LEN_W) + 2;
    localparam logic [SW-1:0] NS = SW'(BUFFER_BYTES);
    localparam logic [SW-1:0] HS = SW'(HEADER_BYTES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BEG1 = 3'd1;
    localparam logic [2:0] S_PAYH = 3'd2;
    localparam logic [2:0] S_DRN  = 3'd3;
    localparam logic [2:0] S_HDR0 = 3'd4;
    localparam logic [2:0] S_HDR1 = 3'd5;
    localparam logic [2:0] S_DATA = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
        logic [SW-1:0] t;
        t = (s >= NS) ? s - NS : s;
        return t[AW-1:0];
    endfunction

    function automatic logic [FW-1:0] sub_sat(input logic [FW-1:0] u,
                                              input logic [SW-1:0] x);
        logic [SW-1:0] ue;
        logic [SW-1:0] d;
        ue = SW'(u);
        d  = (x > ue) ? '0 : ue - x;
        return d[FW-1:0];
    endfunction

    logic [2:0]       r_state, n_state;
    logic [AW-1:0]    r_wp, n_wp, r_rp, n_rp;
    logic [FW-1:0]    r_used, n_used;
    logic             r_open, n_open;
    logic [AW-1:0]    r_hdr, n_hdr;
    logic [AW-1:0]    r_pay, n_pay;
    logic [LEN_W-1:0] r_olen, n_olen;
    logic [LEN_W-1:0] r_wrem, n_wrem;
    logic             r_drn, n_drn;
    logic [LEN_W-1:0] r_drem, n_drem;
    logic [LEN_W-1:0] r_dlen, n_dlen;
    logic [AW-1:0]    r_rda, n_rda;
    logic [3:0]       r_hi, n_hi;
    logic [7:0]       r_b1, n_b1;

    logic [1:0]       r_res_st, n_res_st;
    logic [7:0]       r_res_do, n_res_do;
    logic             r_res_v, n_res_v;
    logic             r_res_l, n_res_l;
    logic [LEN_W-1:0] r_res_dl, n_res_dl;

    logic             r_ov, n_ov;
    logic [1:0]       r_o_st, n_o_st;
    logic [7:0]       r_o_do, n_o_do;
    logic             r_o_v, n_o_v;
    logic             r_o_l, n_o_l;
    logic [LEN_W-1:0] r_o_dl, n_o_dl;
    logic [FW-1:0]    r_o_fr, n_o_fr;

    logic             we, re;
    logic [AW-1:0]    waddr, raddr;
    logic [7:0]       wdata, rdata;

    logic [LEN_W-1:0] in_len;
    logic [7:0]       in_byte;
    logic [1:0]       in_op;
    logic             acc;
    logic [SW-1:0]    rest_w, skip, need, freeb, rest_r, total;
    logic [AW-1:0]    wp0;
    logic [LEN_W-1:0] hlen;

    assign in_len  = i_s_tdata[LEN_W-1:0];
    assign in_byte = i_s_tdata[19:12];
    assign in_op   = i_s_tuser;
    assign o_s_tready = (r_state == S_IDLE);
    assign acc = i_s_tvalid && o_s_tready;

    always_comb begin
        rest_w = NS - SW'(r_wp);
        skip   = (rest_w < HS) ? rest_w : '0;
        need   = SW'(in_len) + HS + skip;
        freeb  = NS - SW'(r_used);
        wp0    = (skip != '0) ? '0 : r_wp;
        rest_r = NS - SW'(r_rp);
        hlen   = {r_hi, rdata};
        total  = SW'(r_dlen) + HS;
    end

    always_comb begin
        n_state = r_state;  n_wp = r_wp;     n_rp = r_rp;     n_used = r_used;
        n_open = r_open;    n_hdr = r_hdr;   n_pay = r_pay;   n_olen = r_olen;
        n_wrem = r_wrem;    n_drn = r_drn;   n_drem = r_drem; n_dlen = r_dlen;
        n_rda = r_rda;      n_hi = r_hi;     n_b1 = r_b1;
        n_res_st = r_res_st; n_res_do = r_res_do; n_res_v = r_res_v;
        n_res_l = r_res_l;  n_res_dl = r_res_dl;
        n_ov = r_ov;        n_o_st = r_o_st; n_o_do = r_o_do; n_o_v = r_o_v;
        n_o_l = r_o_l;      n_o_dl = r_o_dl; n_o_fr = r_o_fr;
        we = 1'b0; waddr = '0; wdata = '0;
        re = 1'b0; raddr = '0;

        if (r_ov && i_m_tready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_res_st = ST_OK; n_res_do = '0; n_res_v = 1'b0;
                    n_res_l = 1'b0;   n_res_dl = '0;
                    n_state = S_DONE;
                    case (in_op)
                        OP_BEGIN: begin
                            if (r_open) begin
                                n_res_st = ST_SEQUENCE;
                            end else if (need > freeb) begin
                                n_res_st = ST_NO_SPACE;
                            end else begin
                                n_used = r_used + need[FW-1:0];
                                n_hdr  = wp0;
                                we     = 1'b1;
                                waddr  = wp0;
                                wdata  = {in_len[11:8], 3'b000, (in_len == '0)};
                                n_wp   = wrap(SW'(wp0) + HS + SW'(in_len));
                                n_pay  = wrap(SW'(wp0) + HS);
                                n_b1   = in_len[7:0];
                                n_olen = in_len;
                                if (in_len != '0) begin
                                    n_open = 1'b1;
                                    n_wrem = in_len;
                                end
                                n_state = S_BEG1;
                            end
                        end
                        OP_PAYLOAD: begin
                            if (!r_open) begin
                                n_res_st = ST_SEQUENCE;
                            end else begin
                                we    = 1'b1;
                                waddr = r_pay;
                                wdata = in_byte;
                                n_pay = wrap(SW'(r_pay) + SW'(1));
                                n_wrem = r_wrem - LEN_W'(1);
                                if (r_wrem == LEN_W'(1)) begin
                                    n_open  = 1'b0;
                                    n_state = S_PAYH;
                                end
                            end
                        end
                        OP_DRAIN: begin
                            n_state = S_DRN;
                        end
                        default: begin
                            n_res_st = ST_SEQUENCE;
                        end
                    endcase
                end
            end
            S_BEG1: begin
                // The second header byte sits right after the first one.
                we      = 1'b1;
                waddr   = wrap(SW'(r_hdr) + SW'(1));
                wdata   = r_b1;
                n_state = S_DONE;
            end
            S_PAYH: begin
                we      = 1'b1;
                waddr   = r_hdr;
                wdata   = {r_olen[11:8], 3'b000, 1'b1};
                n_state = S_DONE;
            end
            S_DRN: begin
                if (r_drn) begin
                    re      = 1'b1;
                    raddr   = r_rda;
                    n_state = S_DATA;
                end else if (r_used == '0) begin
                    n_res_st = ST_NOTHING;
                    n_state  = S_DONE;
                end else if (rest_r < HS) begin
                    n_used = sub_sat(r_used, rest_r);
                    n_rp   = '0;
                end else begin
                    re      = 1'b1;
                    raddr   = r_rp;
                    n_state = S_HDR0;
                end
            end
            S_HDR0: begin
                if (!rdata[0]) begin
                    n_res_st = ST_NOTHING;
                    n_state  = S_DONE;
                end else begin
                    n_hi    = rdata[7:4];
                    re      = 1'b1;
                    raddr   = wrap(SW'(r_rp) + SW'(1));
                    n_state = S_HDR1;
                end
            end
            S_HDR1: begin
                if (hlen == '0) begin
                    n_used = sub_sat(r_used, HS);
                    n_rp   = wrap(SW'(r_rp) + HS);
                end else begin
                    n_drn  = 1'b1;
                    n_drem = hlen;
                    n_dlen = hlen;
                    n_rda  = wrap(SW'(r_rp) + HS);
                end
                n_state = S_DRN;
            end
            S_DATA: begin
                n_res_do = rdata;
                n_res_v  = 1'b1;
                n_res_dl = r_dlen;
                n_drem   = r_drem - LEN_W'(1);
                n_rda    = wrap(SW'(r_rda) + SW'(1));
                if (r_drem == LEN_W'(1)) begin
                    n_res_l = 1'b1;
                    n_drn   = 1'b0;
                    n_used  = sub_sat(r_used, total);
                    n_rp    = wrap(SW'(r_rp) + total);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || i_m_tready) begin
                    n_ov    = 1'b1;
                    n_o_st  = r_res_st;
                    n_o_do  = r_res_do;
                    n_o_v   = r_res_v;
                    n_o_l   = r_res_l;
                    n_o_dl  = r_res_dl;
                    n_o_fr  = FW'(NS - SW'(r_used));
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp    <= '0;
            r_rp    <= '0;
            r_used  <= '0;
            r_open  <= 1'b0;
            r_wrem  <= '0;
            r_drn   <= 1'b0;
            r_drem  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_used  <= n_used;
            r_open  <= n_open;
            r_wrem  <= n_wrem;
            r_drn   <= n_drn;
            r_drem  <= n_drem;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr    <= n_hdr;
        r_pay    <= n_pay;
        r_olen   <= n_olen;
        r_dlen   <= n_dlen;
        r_rda    <= n_rda;
        r_hi     <= n_hi;
        r_b1     <= n_b1;
        r_res_st <= n_res_st;
        r_res_do <= n_res_do;
        r_res_v  <= n_res_v;
        r_res_l  <= n_res_l;
        r_res_dl <= n_res_dl;
        r_o_st   <= n_o_st;
        r_o_do   <= n_o_do;
        r_o_v    <= n_o_v;
        r_o_l    <= n_o_l;
        r_o_dl   <= n_o_dl;
        r_o_fr   <= n_o_fr;
    end

    vrrb_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = OW'({r_o_fr, r_o_dl, r_o_do});
    assign o_m_tuser  = {r_o_v, r_o_st};
    assign o_m_tlast  = r_o_l;

endmodule

FILE: rtl/vrrb_checker.sv
// Port-level checker for the variable-length record ring buffer, bound to the top.
// Depends on vrrb_pkg and variable_record_ring_buffer.
`timescale 1ns / 1ps

module vrrb_checker
    import vrrb_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
    parameter int OW = 40
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_s_tvalid,
    input logic          o_s_tready,
    input logic          o_m_tvalid,
    input logic          i_m_tready,
    input logic [OW-1:0] o_m_tdata,
    input logic [2:0]    o_m_tuser,
    input logic          o_m_tlast
);

    localparam int FW = $clog2(BUFFER_BYTES) + 1;

    // A last-byte mark only rides on a drained byte, and a drained byte reports ok.
    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tlast || o_m_tuser[2]) |-> o_m_tuser[2] && o_m_tuser[1:0] == ST_OK)
        else $error("tlast or drained byte with bad flags");

    // Without a drained byte the data and length fields read zero.
    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[2] |-> o_m_tdata[19:0] == 20'd0)
        else $error("data fields set on a result without data");

    // Free space never exceeds the ring size.
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[FW+19:20] <= FW'(BUFFER_BYTES))
        else $error("free byte count above ring size");

    // A result that is held off stays on the bus unchanged.
    a_hold_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
                                      $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while held off");

    // Only one request is worked on at a time.
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken while busy");

endmodule

bind variable_record_ring_buffer vrrb_checker #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .OW           (OW)
) u_vrrb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

FILE: tb/tb_variable_record_ring_buffer.sv
// Self-checking testbench for the variable-length record ring buffer.
// Depends on vrrb_pkg and the variable_record_ring_buffer RTL; a built-in ring
// model predicts every response and a monitor checks each one in order.
`timescale 1ns / 1ps

module tb_variable_record_ring_buffer;
    import vrrb_pkg::*;

    localparam int RING       = 4096;
    localparam int HDR        = 5;
    localparam int MAX_CYCLES = 1000000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  data_out;
        logic        data_valid;
        logic        last_of_entry;
        logic [11:0] drained_len;
        logic [12:0] free_bytes;
    } t_ring_resp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;   // entry_length[11:0], data_byte[19:12]
    logic [1:0]  i_s_tuser;   // operation[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;   // data_out[7:0], drained_entry_length[19:8], free_bytes[32:20]
    logic [2:0]  o_m_tuser;   // status[1:0], data_valid[2]
    logic        o_m_tlast;

    variable_record_ring_buffer DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast)
    );

    // Shadow copy of the ring and its pointers.
    logic [7:0] ring_mem [RING];
    int wr_pos, rd_pos, used_cnt, hdr_pos, wr_left, rd_left;
    bit rec_open, rd_active;

    t_ring_resp pending_resp [$];
    int  err_count, cycle_count, req_count, resp_count, bytes_drained;
    bit  tx_gaps, rx_gaps;
    int  rx_hold;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at response %0d: %s got %0d expected %0d",
                 resp_count, what, got, want);
        err_count++;
    endtask

    function automatic int hdr_length(input int p);
        return {ring_mem[p][7:4], ring_mem[(p + 1) % RING]};
    endfunction

    function automatic t_ring_resp ring_predict(input logic [1:0] op, input int len,
                                                input logic [7:0] db);
        t_ring_resp r;
        int rest, skip, need, l, off;
        r = '0;
        // Only the low 12 bits of the length travel on the bus.
        len = len & 32'hFFF;
        if (op == OP_BEGIN) begin
            if (rec_open) begin
                r.status = ST_SEQUENCE;
            end else begin
                rest = RING - wr_pos;
                skip = (rest < HDR) ? rest : 0;
                need = len + HDR + skip;
                if (need > RING - used_cnt) begin
                    r.status = ST_NO_SPACE;
                end else begin
                    used_cnt += need;
                    if (skip != 0) wr_pos = 0;
                    hdr_pos = wr_pos;
                    ring_mem[wr_pos] = {len[11:8], 3'b000, len == 0};
                    ring_mem[(wr_pos + 1) % RING] = len[7:0];
                    for (int i = 2; i < HDR; i++) ring_mem[(wr_pos + i) % RING] = 8'h00;
                    wr_pos = (wr_pos + HDR + len) % RING;
                    if (len != 0) begin
                        rec_open = 1'b1;
                        wr_left  = len;
                    end
                end
            end
        end else if (op == OP_PAYLOAD) begin
            if (!rec_open) begin
                r.status = ST_SEQUENCE;
            end else begin
                off = hdr_length(hdr_pos) - wr_left;
                ring_mem[(hdr_pos + HDR + off) % RING] = db;
                wr_left--;
                if (wr_left == 0) begin
                    ring_mem[hdr_pos][0] = 1'b1;
                    rec_open = 1'b0;
                end
            end
        end else if (op == OP_DRAIN) begin
            // Walk past short tails and empty records until a ready record is found.
            while (!rd_active) begin
                if (used_cnt == 0) begin
                    r.status = ST_NOTHING;
                    break;
                end
                rest = RING - rd_pos;
                if (rest < HDR) begin
                    used_cnt = (rest > used_cnt) ? 0 : used_cnt - rest;
                    rd_pos = 0;
                    continue;
                end
                if (!ring_mem[rd_pos][0]) begin
                    r.status = ST_NOTHING;
                    break;
                end
                l = hdr_length(rd_pos);
                ring_mem[rd_pos][0] = 1'b0;
                if (l == 0) begin
                    used_cnt = (used_cnt < HDR) ? 0 : used_cnt - HDR;
                    rd_pos = (rd_pos + HDR) % RING;
                    continue;
                end
                rd_active = 1'b1;
                rd_left = l;
            end
            if (rd_active) begin
                l = hdr_length(rd_pos);
                off = l - rd_left;
                r.data_out    = ring_mem[(rd_pos + HDR + off) % RING];
                r.data_valid  = 1'b1;
                r.drained_len = l;
                rd_left--;
                if (rd_left == 0) begin
                    r.last_of_entry = 1'b1;
                    rd_active = 1'b0;
                    used_cnt = (l + HDR > used_cnt) ? 0 : used_cnt - (l + HDR);
                    rd_pos = (rd_pos + l + HDR) % RING;
                end
            end
        end else begin
            r.status = ST_SEQUENCE;
        end
        r.free_bytes = RING - used_cnt;
        return r;
    endfunction

    task automatic send_req(input logic [1:0] op, input int len, input logic [7:0] db);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0000, db, len[11:0]};
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_resp.push_back(ring_predict(op, len, db));
        req_count++;
    endtask

    task automatic wait_quiet();
        i_s_tvalid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // Sends a begin and, if it opened a record, all of its payload bytes.
    task automatic send_record(input int len);
        send_req(OP_BEGIN, len, $urandom);
        while (rec_open) send_req(OP_PAYLOAD, $urandom, $urandom);
    endtask

    task automatic drain_all();
        while (used_cnt != 0 && !(rec_open && rd_pos == hdr_pos))
            send_req(OP_DRAIN, $urandom, $urandom);
        send_req(OP_DRAIN, $urandom, $urandom);
    endtask

    always @(posedge i_clk) begin
        t_ring_resp w;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_resp.size() == 0) begin
                report_mismatch("unexpected response, queue depth", 0, 0);
            end else begin
                w = pending_resp.pop_front();
                if (o_m_tuser[1:0] !== w.status)
                    report_mismatch("status", o_m_tuser[1:0], w.status);
                if (o_m_tuser[2] !== w.data_valid)
                    report_mismatch("data_valid", o_m_tuser[2], w.data_valid);
                if (o_m_tlast !== w.last_of_entry)
                    report_mismatch("last_of_entry", o_m_tlast, w.last_of_entry);
                if (o_m_tdata[7:0] !== w.data_out)
                    report_mismatch("data_out", o_m_tdata[7:0], w.data_out);
                if (o_m_tdata[19:8] !== w.drained_len)
                    report_mismatch("drained_entry_length", o_m_tdata[19:8], w.drained_len);
                if (o_m_tdata[32:20] !== w.free_bytes)
                    report_mismatch("free_bytes", o_m_tdata[32:20], w.free_bytes);
                if (w.data_valid) bytes_drained++;
            end
            resp_count++;
        end
    end

    // Receiver: long hold-offs on request, otherwise short random stalls.
    always @(posedge i_clk) begin
        int stall;
        if (rx_hold > 0) begin
            i_m_tready <= 1'b0;
            rx_hold--;
        end else if (stall > 0) begin
            i_m_tready <= 1'b0;
            stall--;
        end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
            i_m_tready <= 1'b0;
            stall = $urandom_range(0, 2);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_variable_record_ring_buffer NOT OK");
            $finish;
        end
    end

    task automatic test_idle_errors();
        send_req(OP_DRAIN, 12'hFFF, 8'hFF);
        send_req(OP_PAYLOAD, 0, 8'h00);
        send_req(OP_UNUSED, 12'hFFF, 8'hFF);
        wait_quiet();
    endtask

    task automatic test_directed_ops();
        send_req(OP_BEGIN, 0, 8'h00);          // empty record, ready at once
        send_req(OP_BEGIN, 3, 8'h00);
        send_req(OP_BEGIN, 4091, 8'hFF);       // begin while a record is open
        send_req(OP_PAYLOAD, 12'hFFF, 8'h00);
        send_req(OP_DRAIN, 0, 8'h00);          // oldest open record is not ready yet
        send_req(OP_PAYLOAD, 0, 8'hFF);
        send_req(OP_PAYLOAD, 0, 8'hA5);
        send_req(OP_UNUSED, 0, 8'h00);
        send_req(OP_BEGIN, 4091, 8'h00);       // no space with bytes in use
        repeat (4) send_req(OP_DRAIN, 0, 8'h00);
        wait_quiet();
    endtask

    // Fills the whole ring with empty records. A short first record lines the
    // write pointer up so that a three-byte tail is skipped at the ring end,
    // and the fill stops with a begin that finds no space. One drain then
    // walks every record and the skipped tail.
    task automatic test_fill_ring();
        int rest, skip, len;
        rest = RING - wr_pos;
        len = (rest >= 8 + HDR) ? (rest - 8) % 5 : 0;
        send_record(len);
        forever begin
            rest = RING - wr_pos;
            skip = (rest < HDR) ? rest : 0;
            if (HDR + skip > RING - used_cnt) break;
            send_req(OP_BEGIN, 0, 8'h00);
        end
        send_req(OP_BEGIN, 0, 8'h00);          // ring is full
        drain_all();
        wait_quiet();
    endtask

    task automatic test_backpressure();
        rx_hold = 300;
        send_record(20);
        repeat (8) send_req(OP_DRAIN, 0, 8'h00);
        wait_quiet();
        drain_all();
        wait_quiet();
    endtask

    task automatic test_random(input int target);
        int start, k, len;
        start = req_count;
        while (req_count - start < target) begin
            if (req_count - start > target - 30) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            k = $urandom_range(0, 99);
            if (k < 65) begin
                len = $urandom_range(0, 24);
                send_req(OP_BEGIN, len, $urandom);
                while (rec_open) begin
                    k = $urandom_range(0, 19);
                    if (k == 0) send_req(OP_DRAIN, $urandom, $urandom);
                    else if (k == 1) send_req(OP_BEGIN, $urandom, $urandom);
                    else send_req(OP_PAYLOAD, $urandom, $urandom);
                end
            end else if (k < 85) begin
                repeat ($urandom_range(1, 20)) send_req(OP_DRAIN, $urandom, $urandom);
            end else begin
                send_req($urandom_range(1, 3), $urandom, $urandom);
            end
        end
        drain_all();
        wait_quiet();
    endtask

    initial begin
        for (int i = 0; i < RING; i++) ring_mem[i] = 8'h00;
        {wr_pos, rd_pos, used_cnt, hdr_pos, wr_left, rd_left} = '0;
        rec_open = 0; rd_active = 0;
        err_count = 0; cycle_count = 0; req_count = 0; resp_count = 0;
        bytes_drained = 0; rx_hold = 0;
        tx_gaps = 1'b1; rx_gaps = 1'b1;
        i_rst_n = 1'b0; i_s_tvalid = 1'b0; i_s_tdata = '0; i_s_tuser = OP_BEGIN;
        i_m_tready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_errors();
        test_directed_ops();
        test_backpressure();
        test_fill_ring();
        test_random(50);

        $display("Covered %0d requests and %0d responses, %0d payload bytes drained,",
                 req_count, resp_count, bytes_drained);
        $display("including a full ring lap with a skipped tail and long output stalls.");
        if (err_count == 0) begin
            $display("tb_variable_record_ring_buffer OK");
        end else begin
            $display("%0d mismatches", err_count);
            $display("tb_variable_record_ring_buffer NOT OK");
        end
        $finish;
    end

endmodule
